### src/fisher_yates_shuffle_engine_core_macros.svh
// Assertion macros shared by the shuffle engine checker.
`ifndef FISHER_YATES_SHUFFLE_ENGINE_CORE_MACROS_SVH
`define FISHER_YATES_SHUFFLE_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define FYSE_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define FYSE_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/fyse_pkg.sv
// Package with the types and constants of the shuffle engine.
package fyse_pkg;

	localparam int unsigned RW_W    = 16;
	localparam int unsigned DIV_CNT_W = $clog2(RW_W);
	localparam int unsigned OUT_W   = 6;
	localparam int unsigned S_TDATA_W = 16;
	localparam int unsigned M_TDATA_W = 16;
	localparam int unsigned M_PAD_W = M_TDATA_W - 2 * OUT_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_RD_J,
		ST_RD_TOP,
		ST_WR_J,
		ST_WR_TOP
	} fyse_state_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic rd_j;
		logic rd_top;
		logic cap_j;
		logic wr_j;
		logic wr_top;
		logic finish;
	} fyse_cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_free;
	} fyse_status_t;

endpackage

### src/fyse_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module fyse_ram #(
	parameter int unsigned WIDTH = 6,
	parameter int unsigned DEPTH = 52
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### src/fyse_datapath.sv
// Datapath of the shuffle engine: divider, deck memory, counter and output register.
module fyse_datapath #(
	parameter int unsigned DECK_SIZE = 52
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  fyse_pkg::fyse_cmd_t               cmd,
	output fyse_pkg::fyse_status_t            status,
	input  logic [fyse_pkg::S_TDATA_W-1:0]    s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [fyse_pkg::M_TDATA_W-1:0]    m_tdata,
	output logic                              m_tlast
);

	localparam int unsigned AW = (DECK_SIZE > 1) ? $clog2(DECK_SIZE) : 1;
	localparam int unsigned CW = $clog2(DECK_SIZE + 1);

	logic [CW-1:0]                    rem_cnt_q;
	logic [fyse_pkg::RW_W-1:0]        dv_q;
	logic [CW-1:0]                    r_q;
	logic [fyse_pkg::DIV_CNT_W-1:0]   div_cnt_q;
	logic [CW:0]                      shifted;
	logic [CW:0]                      n_ext;
	logic [CW-1:0]                    r_next;
	logic [AW-1:0]                    j_addr;
	logic [AW-1:0]                    top_addr;
	logic                             is_final;
	logic [DECK_SIZE-1:0]             valid_q;
	logic                             rvalid_q;
	logic [AW-1:0]                    raddr_q;
	logic [AW-1:0]                    raddr;
	logic [fyse_pkg::OUT_W-1:0]       rdata;
	logic [fyse_pkg::OUT_W-1:0]       rd_card;
	logic [fyse_pkg::OUT_W-1:0]       jcard_q;
	logic                             ram_we;
	logic [AW-1:0]                    ram_waddr;
	logic [fyse_pkg::OUT_W-1:0]       ram_wdata;
	logic                             out_valid_q;
	logic [fyse_pkg::OUT_W-1:0]       out_slot_q;
	logic [fyse_pkg::OUT_W-1:0]       out_card_q;
	logic                             out_last_q;

	assign n_ext    = {1'b0, rem_cnt_q};
	assign shifted  = {r_q, dv_q[fyse_pkg::RW_W-1]};
	assign r_next   = (shifted >= n_ext) ? CW'(shifted - n_ext) : CW'(shifted);
	assign j_addr   = r_q[AW-1:0];
	assign top_addr = AW'(rem_cnt_q - 1'b1);
	assign is_final = (rem_cnt_q == CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.load) begin
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dv_q <= s_tdata[fyse_pkg::RW_W-1:0];
			r_q  <= '0;
		end else if (cmd.div_step) begin
			dv_q <= {dv_q[fyse_pkg::RW_W-2:0], 1'b0};
			r_q  <= r_next;
		end
	end

	assign raddr = cmd.rd_j ? j_addr : top_addr;

	always_ff @(posedge clk) begin
		if (cmd.rd_j || cmd.rd_top) begin
			rvalid_q <= valid_q[raddr];
			raddr_q  <= raddr;
		end
	end

	assign rd_card = rvalid_q ? rdata : fyse_pkg::OUT_W'(raddr_q);

	always_ff @(posedge clk) begin
		if (cmd.cap_j) begin
			jcard_q <= rd_card;
		end
	end

	assign ram_we    = cmd.wr_j || cmd.wr_top;
	assign ram_waddr = cmd.wr_j ? j_addr : top_addr;
	assign ram_wdata = cmd.wr_j ? rd_card : jcard_q;

	fyse_ram #(
		.WIDTH(fyse_pkg::OUT_W),
		.DEPTH(DECK_SIZE)
	) u_deck_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.rd_j || cmd.rd_top),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rem_cnt_q <= CW'(DECK_SIZE);
		end else if (cmd.finish) begin
			if (is_final) begin
				valid_q   <= '0;
				rem_cnt_q <= CW'(DECK_SIZE);
			end else begin
				valid_q[top_addr] <= 1'b1;
				rem_cnt_q         <= rem_cnt_q - 1'b1;
			end
		end else if (ram_we) begin
			valid_q[ram_waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_slot_q <= fyse_pkg::OUT_W'(top_addr);
			out_card_q <= jcard_q;
			out_last_q <= is_final;
		end
	end

	assign status.div_done = (div_cnt_q == fyse_pkg::DIV_CNT_W'(fyse_pkg::RW_W - 1));
	assign status.out_free = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{fyse_pkg::M_PAD_W{1'b0}}, out_card_q, out_slot_q};
	assign m_tlast  = out_last_q;

endmodule

### src/fyse_ctrl.sv
// Controller state machine that sequences the divide, swap and output steps.
module fyse_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  fyse_pkg::fyse_status_t status,
	output fyse_pkg::fyse_cmd_t    cmd
);

	fyse_pkg::fyse_state_t state_q;
	fyse_pkg::fyse_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fyse_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			fyse_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_d = fyse_pkg::ST_DIV;
				end
			end
			fyse_pkg::ST_DIV: begin
				if (status.div_done) begin
					state_d = fyse_pkg::ST_RD_J;
				end
			end
			fyse_pkg::ST_RD_J:   state_d = fyse_pkg::ST_RD_TOP;
			fyse_pkg::ST_RD_TOP: state_d = fyse_pkg::ST_WR_J;
			fyse_pkg::ST_WR_J:   state_d = fyse_pkg::ST_WR_TOP;
			fyse_pkg::ST_WR_TOP: begin
				if (status.out_free) begin
					state_d = fyse_pkg::ST_IDLE;
				end
			end
			default: state_d = fyse_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			fyse_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			fyse_pkg::ST_DIV:    cmd.div_step = 1'b1;
			fyse_pkg::ST_RD_J:   cmd.rd_j = 1'b1;
			fyse_pkg::ST_RD_TOP: begin
				cmd.rd_top = 1'b1;
				cmd.cap_j  = 1'b1;
			end
			fyse_pkg::ST_WR_J:   cmd.wr_j = 1'b1;
			fyse_pkg::ST_WR_TOP: begin
				cmd.wr_top = 1'b1;
				cmd.finish = status.out_free;
			end
			default: cmd = '0;
		endcase
	end

endmodule

### src/fisher_yates_shuffle_engine_core.sv
// Top level of the Fisher-Yates shuffle engine.
//
//   channel   dir   handshake            contents
//   s_*       in    s_tvalid/s_tready    random word, one per swap step
//   m_*       out   m_tvalid/m_tready    finalized slot and card, tlast on the final step
//
// One transaction passes from acceptance to the result register through the accept
// state, the bit-serial remainder unit, and the RD_J, RD_TOP, WR_J and WR_TOP states on
// the single read and write ports of the deck memory for the swap.
// Reset leaves the deck as identity through per-slot valid bits, so no clearing pass
// is needed; the final step of a permutation clears them.
// A stalled result holds in the output register while the next transaction is accepted.
module fisher_yates_shuffle_engine_core #(
	parameter int unsigned DECK_SIZE = 52
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [fyse_pkg::S_TDATA_W-1:0] s_tdata,  // [15:0] random_word
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [fyse_pkg::M_TDATA_W-1:0] m_tdata,  // [5:0] slot, [11:6] card_code, [15:12] zero
	output logic                           m_tlast
);

	fyse_pkg::fyse_cmd_t    cmd;
	fyse_pkg::fyse_status_t status;

	fyse_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.status  (status),
		.cmd     (cmd)
	);

	fyse_datapath #(
		.DECK_SIZE(DECK_SIZE)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.status  (status),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

endmodule

### src/fyse_checker.sv
// Port-level assertion checker for the shuffle engine and its bind statement.
`include "fisher_yates_shuffle_engine_core_macros.svh"

module fyse_checker #(
	parameter int unsigned DECK_SIZE = 52
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [fyse_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                           m_tlast
);

	`FYSE_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "Stalled result changed.")
	`FYSE_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "Input accepted while a step is in progress.")
	`FYSE_ASSERT_IMP(a_last_slot_zero, m_tvalid && m_tlast, m_tdata[5:0] == 6'd0, "Final result is not for slot zero.")
	`FYSE_ASSERT_IMP(a_card_range, m_tvalid, (m_tdata[11:6] < DECK_SIZE) && (m_tdata[5:0] < DECK_SIZE), "Slot or card out of deck range.")

endmodule

bind fisher_yates_shuffle_engine_core fyse_checker #(
	.DECK_SIZE(DECK_SIZE)
) u_fyse_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast)
);
